@@ design/kpib_pkg.sv @@
`timescale 1ns / 1ps

package kpib_pkg;

  // Field and register widths fixed by the interface.
  localparam int CMD_W      = 3;
  localparam int BASE_W     = 8;
  localparam int INDEX_W    = 23;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int KMER_LEN_W  = 4;
  localparam int READ_LEN_W  = 8;
  localparam int STRIDE_W    = 4;
  localparam int BLK_CNT_W   = 5;
  localparam int BLK_STEP_W  = 7;
  localparam int COUNT_W     = 32;
  localparam int RNUM_W      = 48;

  // Block start is at most read_length - k * stride; a key position adds under (k + 1) * stride more.
  localparam int SPAN_W  = 11;
  localparam int START_W = 13;
  localparam int KST_W   = 9;
  localparam int LIM_W   = 16;

  // Command codes of an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT  = 3'd0,
    CMD_FINISH = 3'd1,
    CMD_PLACE  = 3'd2,
    CMD_RD_OFF = 3'd3,
    CMD_RD_POS = 3'd4
  } cmd_code_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LEN  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STEP  = 3'd4;

  // Configuration values after reset.
  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST    = 4'd11;
  localparam logic [READ_LEN_W-1:0] READ_LENGTH_RST = 8'd64;
  localparam logic [STRIDE_W-1:0]   STRIDE_RST      = 4'd1;
  localparam logic [BLK_CNT_W-1:0]  BLOCK_COUNT_RST = 5'd2;
  localparam logic [BLK_STEP_W-1:0] BLOCK_STEP_RST  = 7'd5;

  // Largest valid nucleotide code.
  localparam logic [BASE_W-1:0] BASE_MAX = 8'd3;
  localparam logic [2:0]        BASE_BAD = 3'd4;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_BASE,
    ST_EOR,
    ST_NBLK,
    ST_OVF,
    ST_BLK,
    ST_BUF_RD,
    ST_BUF_ACC,
    ST_TBL_RD,
    ST_TBL_WR,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_FIN_END,
    ST_MEM_RD,
    ST_EMIT
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic latch;
    logic decode;
    logic store_base;
    logic eor;
    logic nblk;
    logic ovf;
    logic blk;
    logic buf_rd;
    logic buf_acc;
    logic tbl_rd;
    logic tbl_wr;
    logic fin_rd;
    logic fin_wr;
    logic fin_end;
    logic mem_rd;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      clr_done;
    cmd_code_t cmd;
    logic      last;
    logic      mismatch;
    logic      placing;
    logic      blk_more;
    logic      ovf;
    logic      blk_left;
    logic      key_done;
    logic      second;
    logic      fin_done;
    logic      out_free;
  } dp_stat_t;

endpackage

@@ design/kpib_ifs.sv @@
`timescale 1ns / 1ps

interface kpib_req_if;
  import kpib_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BASE_W-1:0] base;
  logic              last_base;
  logic [INDEX_W-1:0] index;
  modport source (output valid, cmd, base, last_base, index, input ready);
  modport sink (input valid, cmd, base, last_base, index, output ready);
endinterface

interface kpib_rsp_if;
  import kpib_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  logic [STAT_W-1:0] status;
  modport source (output valid, data, status, input ready);
  modport sink (input valid, data, status, output ready);
endinterface

interface kpib_cfg_if;
  import kpib_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/kpib_ctrl.sv @@
`timescale 1ns / 1ps

module kpib_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kpib_pkg::dp_stat_t  stat,
  output kpib_pkg::ctrl_cmd_t cmd
);
  import kpib_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  // State register; reset starts the table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (stat.clr_done) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        case (stat.cmd)
          CMD_COUNT, CMD_PLACE:   state_next = ST_BASE;
          CMD_FINISH:             state_next = ST_FIN_RD;
          CMD_RD_OFF, CMD_RD_POS: state_next = ST_MEM_RD;
          default:                state_next = ST_IDLE;
        endcase
      end
      ST_BASE:    state_next = stat.last ? ST_EOR : ST_IDLE;
      ST_EOR:     state_next = stat.mismatch ? ST_EMIT : ST_NBLK;
      ST_NBLK: begin
        if (!stat.blk_more) state_next = stat.placing ? ST_BLK : ST_OVF;
      end
      ST_OVF:     state_next = stat.ovf ? ST_EMIT : ST_BLK;
      ST_BLK:     state_next = stat.blk_left ? ST_BUF_RD : ST_EMIT;
      ST_BUF_RD:  state_next = stat.key_done ? ST_TBL_RD : ST_BUF_ACC;
      ST_BUF_ACC: state_next = ST_BUF_RD;
      ST_TBL_RD:  state_next = ST_TBL_WR;
      ST_TBL_WR:  state_next = stat.second ? ST_BLK : ST_BUF_RD;
      ST_FIN_RD:  state_next = stat.fin_done ? ST_FIN_END : ST_FIN_WR;
      ST_FIN_WR:  state_next = ST_FIN_RD;
      ST_FIN_END: state_next = ST_EMIT;
      ST_MEM_RD:  state_next = ST_EMIT;
      ST_EMIT:    if (stat.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR:   cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DECODE:  cmd.decode = 1'b1;
      ST_BASE:    cmd.store_base = 1'b1;
      ST_EOR:     cmd.eor = 1'b1;
      ST_NBLK:    cmd.nblk = 1'b1;
      ST_OVF:     cmd.ovf = 1'b1;
      ST_BLK:     cmd.blk = 1'b1;
      ST_BUF_RD:  cmd.buf_rd = 1'b1;
      ST_BUF_ACC: cmd.buf_acc = 1'b1;
      ST_TBL_RD:  cmd.tbl_rd = 1'b1;
      ST_TBL_WR:  cmd.tbl_wr = 1'b1;
      ST_FIN_RD:  cmd.fin_rd = 1'b1;
      ST_FIN_WR:  cmd.fin_wr = 1'b1;
      ST_FIN_END: cmd.fin_end = 1'b1;
      ST_MEM_RD:  cmd.mem_rd = 1'b1;
      ST_EMIT:    cmd.emit = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ design/kpib_dp.sv @@
`timescale 1ns / 1ps

module kpib_dp #(
  parameter int KMER_MAX  = 11,
  parameter int READ_MAX  = 128,
  parameter int POS_DEPTH = 1048576,
  parameter int POS_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [kpib_pkg::CMD_W-1:0]   in_cmd,
  input  logic [kpib_pkg::BASE_W-1:0]  in_base,
  input  logic                         in_last,
  input  logic [kpib_pkg::INDEX_W-1:0] in_index,
  input  kpib_pkg::ctrl_cmd_t          cmd,
  output kpib_pkg::dp_stat_t           stat,
  kpib_rsp_if.source                   rsp,
  kpib_cfg_if.sink                     cfg
);
  import kpib_pkg::*;

  localparam int  KEYW       = 2 * KMER_MAX;
  localparam int  TW         = KEYW + 1;
  localparam logic [63:0] TABLE_KEYS = 64'd1 << KEYW;
  localparam int  KW         = $clog2(KMER_MAX + 1);
  localparam int  RBW        = $clog2(READ_MAX);
  localparam int  BCW        = $clog2(READ_MAX + 2);
  localparam int  PAW        = $clog2(POS_DEPTH);

  // Configuration registers.
  logic [KMER_LEN_W-1:0] kmer_len;
  logic [READ_LEN_W-1:0] read_length;
  logic [STRIDE_W-1:0]   stride;
  logic [BLK_CNT_W-1:0]  block_count;
  logic [BLK_STEP_W-1:0] block_step;

  // Latched item.
  cmd_code_t          cmd_q;
  logic [BASE_W-1:0]  base_q;
  logic               last_q;
  logic [INDEX_W-1:0] index_q;

  // Work registers.
  logic [BCW-1:0]       base_count;
  logic [STAT_W-1:0]    status;
  logic [KST_W-1:0]     kst;
  logic [BLK_CNT_W-1:0] blk;
  logic [BLK_CNT_W-1:0] nb;
  logic [SPAN_W-1:0]    span;
  logic [START_W-1:0]   start;
  logic [START_W-1:0]   idx;
  logic [KW-1:0]        step_i;
  logic [KEYW-1:0]      key;
  logic                 key_zero;
  logic                 idx_oor;
  logic                 second;
  logic [TW-1:0]        sweep;
  logic [COUNT_W-1:0]   run;
  logic [COUNT_W-1:0]   total;
  logic [RNUM_W-1:0]    read_number;

  // Memories and their registered read data.
  logic [2:0]         rbuf [READ_MAX];
  logic [2:0]         rbuf_q;
  logic [COUNT_W-1:0] offset_mem [TABLE_KEYS + 1];
  logic [COUNT_W-1:0] fill_mem [TABLE_KEYS];
  logic [DATA_W-1:0]  pos_mem [POS_DEPTH];
  logic [COUNT_W-1:0] off_rd;
  logic [COUNT_W-1:0] fill_rd;
  logic [DATA_W-1:0]  pos_rd;

  // Derived values.
  logic [KW-1:0]       k_eff;
  logic [STRIDE_W-1:0] st_eff;
  logic [TW-1:0]       nk;
  logic [KEYW-1:0]     key_final;
  logic signed [LIM_W-1:0] limit;
  logic [COUNT_W:0]    slot;
  logic                slot_ok;
  logic                off_in_range;
  logic                pos_in_range;
  logic                out_free;
  logic                mismatch;
  logic [DATA_W-1:0]   res_data;
  logic [TW-1:0]       off_ra;
  logic                off_re;

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = KW'(1);
    end else if (32'(kmer_len) > KMER_MAX) begin
      k_eff = KW'(KMER_MAX);
    end else begin
      k_eff = KW'(kmer_len);
    end
  end

  assign st_eff    = (stride == '0) ? STRIDE_W'(1) : stride;
  assign nk        = TW'(1) << (2 * k_eff);
  assign key_final = key_zero ? '0 : key;
  assign limit     = $signed(LIM_W'(read_length)) - $signed(LIM_W'(kst));
  assign slot      = (COUNT_W + 1)'(off_rd) + (COUNT_W + 1)'(fill_rd);
  assign slot_ok   = slot < (COUNT_W + 1)'(POS_DEPTH);
  assign off_in_range = 64'(index_q) <= TABLE_KEYS;
  assign pos_in_range = 64'(index_q) < 64'(POS_DEPTH);
  assign out_free  = !rsp.valid || rsp.ready;
  assign mismatch  = (read_length == '0) || (32'(read_length) > READ_MAX) ||
                     (32'(base_count) != 32'(read_length));

  // Status to the controller.
  always_comb begin
    stat.clr_done = sweep == TW'(TABLE_KEYS);
    stat.cmd      = cmd_q;
    stat.last     = last_q;
    stat.mismatch = mismatch;
    stat.placing  = cmd_q == CMD_PLACE;
    stat.blk_more = (blk < block_count) &&
                    ($signed(LIM_W'(span)) <= limit);
    stat.ovf      = (33'(total) + 33'({nb, 1'b0})) > 33'(POS_DEPTH);
    stat.blk_left = blk < nb;
    stat.key_done = step_i == k_eff;
    stat.second   = second;
    stat.fin_done = sweep == nk;
    stat.out_free = out_free;
  end

  // Configuration writes.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len    <= KMER_LEN_RST;
      read_length <= READ_LENGTH_RST;
      stride      <= STRIDE_RST;
      block_count <= BLOCK_COUNT_RST;
      block_step  <= BLOCK_STEP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KMER_LEN:    kmer_len    <= KMER_LEN_W'(cfg.data);
        REG_READ_LENGTH: read_length <= READ_LEN_W'(cfg.data);
        REG_STRIDE:      stride      <= STRIDE_W'(cfg.data);
        REG_BLOCK_COUNT: block_count <= BLK_CNT_W'(cfg.data);
        REG_BLOCK_STEP:  block_step  <= BLK_STEP_W'(cfg.data);
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q   <= cmd_code_t'(in_cmd);
      base_q  <= in_base;
      last_q  <= in_last;
      index_q <= in_index;
    end
  end

  // Sweep counter for the clearing pass and the prefix pass.
  always_ff @(posedge clk) begin
    if (rst || cmd.decode) begin
      sweep <= '0;
    end else if (cmd.clear || cmd.fin_wr) begin
      sweep <= sweep + TW'(1);
    end
  end

  // Read state: base count, totals and read number.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_count  <= '0;
      total       <= '0;
      read_number <= '0;
    end else begin
      if (cmd.store_base && (32'(base_count) <= READ_MAX)) begin
        base_count <= base_count + BCW'(1);
      end
      if (cmd.eor || cmd.fin_end) begin
        base_count <= '0;
      end
      if (cmd.ovf && !stat.ovf) begin
        total <= total + COUNT_W'({nb, 1'b0});
      end
      if ((cmd.eor && mismatch && stat.placing) ||
          (cmd.blk && !stat.blk_left && stat.placing)) begin
        read_number <= read_number + RNUM_W'(1);
      end
      if (cmd.fin_end) begin
        read_number <= '0;
      end
    end
  end

  // Read buffer.
  always_ff @(posedge clk) begin
    if (cmd.store_base && (32'(base_count) < READ_MAX)) begin
      rbuf[RBW'(base_count)] <= (base_q > BASE_MAX) ? BASE_BAD : base_q[2:0];
    end
    if (cmd.buf_rd && !stat.key_done) begin
      rbuf_q <= rbuf[RBW'(idx)];
    end
  end

  // Block walk and key assembly.
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      status <= STAT_OK;
      run    <= '0;
    end
    if (cmd.eor) begin
      status <= mismatch ? STAT_LEN : STAT_OK;
      kst    <= KST_W'(k_eff) * KST_W'(st_eff);
      blk    <= '0;
      nb     <= '0;
      span   <= '0;
    end
    if (cmd.nblk) begin
      if (stat.blk_more) begin
        nb   <= nb + BLK_CNT_W'(1);
        blk  <= blk + BLK_CNT_W'(1);
        span <= span + SPAN_W'(block_step);
      end else begin
        blk  <= '0;
        span <= '0;
      end
    end
    if (cmd.ovf && stat.ovf) begin
      status <= STAT_FULL;
    end
    if (cmd.blk && stat.blk_left) begin
      start    <= START_W'(span);
      idx      <= START_W'(span);
      step_i   <= '0;
      key      <= '0;
      key_zero <= 1'b0;
      second   <= 1'b0;
    end
    if (cmd.buf_rd) begin
      idx_oor <= 32'(idx) >= READ_MAX;
    end
    if (cmd.buf_acc) begin
      key    <= KEYW'({key, rbuf_q[1:0]});
      step_i <= step_i + KW'(1);
      idx    <= idx + START_W'(st_eff);
      if (idx_oor || rbuf_q > 3'(BASE_MAX)) key_zero <= 1'b1;
    end
    if (cmd.tbl_wr) begin
      if (stat.placing && !slot_ok) status <= STAT_FULL;
      if (!second) begin
        // Second key of the block starts one short of the stride.
        start    <= START_W'(span) + START_W'(st_eff) - START_W'(1);
        idx      <= START_W'(span) + START_W'(st_eff) - START_W'(1);
        step_i   <= '0;
        key      <= '0;
        key_zero <= 1'b0;
        second   <= 1'b1;
      end else begin
        blk  <= blk + BLK_CNT_W'(1);
        span <= span + SPAN_W'(block_step);
      end
    end
    if (cmd.fin_wr) begin
      run <= run + off_rd;
    end
  end

  // Offset table read address.
  always_comb begin
    off_re = cmd.tbl_rd || cmd.fin_rd || (cmd.mem_rd && cmd_q == CMD_RD_OFF);
    if (cmd.tbl_rd) begin
      off_ra = TW'(key_final);
    end else if (cmd.fin_rd) begin
      off_ra = sweep;
    end else begin
      off_ra = TW'(index_q);
    end
  end

  // Offset table.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      offset_mem[sweep] <= '0;
    end else if (cmd.tbl_wr && !stat.placing) begin
      offset_mem[TW'(key_final)] <= off_rd + COUNT_W'(1);
    end else if (cmd.fin_wr) begin
      offset_mem[sweep] <= run;
    end else if (cmd.fin_end) begin
      offset_mem[nk] <= total;
    end
    if (off_re && !(cmd.fin_rd && stat.fin_done)) begin
      off_rd <= offset_mem[off_ra];
    end
  end

  // Fill counts.
  always_ff @(posedge clk) begin
    if (cmd.clear && !stat.clr_done) begin
      fill_mem[KEYW'(sweep)] <= '0;
    end else if (cmd.tbl_wr && stat.placing && slot_ok) begin
      fill_mem[key_final] <= fill_rd + COUNT_W'(1);
    end else if (cmd.fin_wr) begin
      fill_mem[KEYW'(sweep)] <= '0;
    end
    if (cmd.tbl_rd) begin
      fill_rd <= fill_mem[key_final];
    end
  end

  // Position store.
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && stat.placing && slot_ok) begin
      pos_mem[PAW'(slot)] <= DATA_W'({read_number, POS_BITS'(start)});
    end
    if (cmd.mem_rd && cmd_q == CMD_RD_POS) begin
      pos_rd <= pos_mem[PAW'(index_q)];
    end
  end

  // Result word.
  always_comb begin
    case (cmd_q)
      CMD_FINISH: res_data = DATA_W'(total);
      CMD_RD_OFF: res_data = off_in_range ? DATA_W'(off_rd) : '0;
      CMD_RD_POS: res_data = pos_in_range ? pos_rd : '0;
      default:    res_data = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      rsp.data   <= res_data;
      rsp.status <= status;
    end
  end

endmodule

@@ design/kmer_position_index_builder_core.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                          Handshake
// req      in   cmd, base, last_base, index      valid / ready
// rsp      out  data, status                     valid / ready
// cfg      in   index, data                      valid / ready (always ready)
//
// A base item without the end-of-read mark passes the idle, decode and base states.
// At the end of a read, each block builds its key pair one base at a time,
// set by the single-port read buffer and the read-modify-write of the tables.
// Finish counting reads and writes each of the 4^k keys; read-backs read memory once.
// After reset a clearing pass over 4^KMER_MAX + 1 table entries zeroes the tables;
// no item is accepted during it. The result register lets a stalled result wait.
module kmer_position_index_builder_core #(
  parameter int KMER_MAX  = 11,
  parameter int READ_MAX  = 128,
  parameter int POS_DEPTH = 1048576,
  parameter int POS_BITS  = 16
) (
  input logic      clk,
  input logic      rst,
  kpib_req_if.sink req,
  kpib_rsp_if.source rsp,
  kpib_cfg_if.sink cfg
);
  import kpib_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  kpib_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kpib_dp #(
    .KMER_MAX  (KMER_MAX),
    .READ_MAX  (READ_MAX),
    .POS_DEPTH (POS_DEPTH),
    .POS_BITS  (POS_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_cmd   (req.cmd),
    .in_base  (req.base),
    .in_last  (req.last_base),
    .in_index (req.index),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp),
    .cfg      (cfg)
  );

  // No item is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req.ready)
    else $error("item accepted during clearing pass");

  // A result loaded into a free output register shows up next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.out_free) |=> rsp.valid)
    else $error("result lost at output register");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STAT_OK || rsp.status == STAT_LEN ||
                   rsp.status == STAT_FULL))
    else $error("undefined status code");

endmodule
